// File: rtl/tcm_pkg.sv
package tcm_pkg;

   // field widths
   localparam int TORQUE_W = 16;
   localparam int CABLE_W  = 24;
   localparam int TICK_W   = 16;
   localparam int COUNT_W  = 32;
   localparam int RATIO_W  = 10;
   localparam int ZRATIO_W = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // scaled threshold width: 16 bit signed count times up to 11 bit ratio, plus margin
   localparam int THR_W = 28;

   // divide by ten via reciprocal: exact for magnitudes below 699050
   localparam int          SUM_W        = 20;
   localparam int          MAG_W        = 19;
   localparam int          DIV10_SHIFT  = 22;
   localparam logic [MAG_W-1:0] DIV10_MAGIC = 19'd419431;
   localparam logic [MAG_W-1:0] ROUND_HALF  = 19'd5;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   // constant used to undo the truncating percent divide on negative thresholds
   localparam logic signed [THR_W-1:0] PCT_BIAS = 28'sd99;
   localparam logic [7:0] PCT_FULL = 8'd100;

   // register reset values
   localparam logic signed [TORQUE_W-1:0] BOTTOM_RESET  = 16'sd500;
   localparam logic [TICK_W-1:0]          TIMEOUT_RESET = 16'd1000;
   localparam logic [TICK_W-1:0]          FILTER_RESET  = 16'd200;

   // motor direction codes
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_LOAD   = 3'd0,
      CSR_RISE_RATIO  = 3'd1,
      CSR_DROP_RATIO  = 3'd2,
      CSR_ZERO_RATIO  = 3'd3,
      CSR_IGNORE_ZONE = 3'd4,
      CSR_BOTTOM      = 3'd5,
      CSR_TIMEOUT     = 3'd6,
      CSR_FILTER      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TIMEOUT   = 2'd1,
      STATUS_COLLISION = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CAUSE_NONE       = 3'd0,
      CAUSE_ZPOINT     = 3'd1,
      CAUSE_RISE       = 3'd2,
      CAUSE_FLOOR      = 3'd3,
      CAUSE_DROP       = 3'd4
   } cause_type;

   typedef struct packed {
      logic                        frame_valid;
      logic signed [TORQUE_W-1:0]  torque_sample;
      logic [1:0]                  direction;
      logic [CABLE_W-1:0]          cable_pos;
      logic                        zero_search;
      logic                        rebase;
   } tcm_req_type;

   typedef struct packed {
      logic [1:0]                  status;
      logic [2:0]                  cause;
      logic                        timeout_warning;
      logic signed [TORQUE_W-1:0]  stable_torque;
      logic [COUNT_W-1:0]          frame_count;
   } tcm_rsp_type;

   typedef struct packed {
      logic signed [TORQUE_W-1:0]  full_load_torque;
      logic [RATIO_W-1:0]          rise_ratio;
      logic [RATIO_W-1:0]          drop_ratio;
      logic [ZRATIO_W-1:0]         zero_ratio;
      logic [CABLE_W-1:0]          ignore_zone;
      logic signed [TORQUE_W-1:0]  floor_torque;
      logic [TICK_W-1:0]           timeout_ticks;
      logic [TICK_W-1:0]           filter_interval;
   } tcm_cfg_type;

   // limits in the x100 domain: value*100 > limit matches value > trunc(p/100)
   typedef struct packed {
      logic signed [THR_W-1:0]     zpoint_limit;
      logic signed [THR_W-1:0]     rise_limit;
      logic signed [THR_W-1:0]     drop_limit;
   } tcm_thr_type;

   // work carried from the state update stage to the decision stage
   typedef struct packed {
      logic                        timeout;
      logic                        warn;
      logic signed [TORQUE_W-1:0]  current_torque;
      logic signed [TORQUE_W-1:0]  stable_torque;
      logic [1:0]                  direction;
      logic                        cable_ok;
      logic                        zero_search;
      logic [COUNT_W-1:0]          frame_count;
   } tcm_mid_type;

endpackage

// File: rtl/tcm_regs.sv
module tcm_regs import tcm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output tcm_cfg_type           cfg,
   output tcm_thr_type           thr
);

   tcm_cfg_type cfg_ff;
   tcm_thr_type thr_ff;
   tcm_thr_type thr_in;

   logic signed [THR_W-1:0] full_x;
   logic signed [THR_W-1:0] zero_pct;
   logic signed [THR_W-1:0] rise_pct;
   logic signed [THR_W-1:0] drop_pct;
   logic signed [THR_W-1:0] zero_p;
   logic signed [THR_W-1:0] rise_p;
   logic signed [THR_W-1:0] drop_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_load_torque <= '0;
         cfg_ff.rise_ratio       <= '0;
         cfg_ff.drop_ratio       <= '0;
         cfg_ff.zero_ratio       <= '0;
         cfg_ff.ignore_zone      <= '0;
         cfg_ff.floor_torque     <= BOTTOM_RESET;
         cfg_ff.timeout_ticks    <= TIMEOUT_RESET;
         cfg_ff.filter_interval  <= FILTER_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_FULL_LOAD:   cfg_ff.full_load_torque <= csr_wdata[TORQUE_W-1:0];
            CSR_RISE_RATIO:  cfg_ff.rise_ratio       <= csr_wdata[RATIO_W-1:0];
            CSR_DROP_RATIO:  cfg_ff.drop_ratio       <= csr_wdata[RATIO_W-1:0];
            CSR_ZERO_RATIO:  cfg_ff.zero_ratio       <= csr_wdata[ZRATIO_W-1:0];
            CSR_IGNORE_ZONE: cfg_ff.ignore_zone      <= csr_wdata[CABLE_W-1:0];
            CSR_BOTTOM:      cfg_ff.floor_torque     <= csr_wdata[TORQUE_W-1:0];
            CSR_TIMEOUT:     cfg_ff.timeout_ticks    <= csr_wdata[TICK_W-1:0];
            CSR_FILTER:      cfg_ff.filter_interval  <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // full load times percent, then bias negatives so a plain compare matches truncation
   always_comb begin
      full_x   = THR_W'(cfg_ff.full_load_torque);
      zero_pct = $signed(THR_W'(PCT_FULL) + THR_W'(cfg_ff.zero_ratio));
      rise_pct = $signed(THR_W'(cfg_ff.rise_ratio));
      drop_pct = $signed(THR_W'(cfg_ff.drop_ratio));
      zero_p   = full_x * zero_pct;
      rise_p   = full_x * rise_pct;
      drop_p   = full_x * drop_pct;
      thr_in.zpoint_limit = zero_p[THR_W-1] ? zero_p + PCT_BIAS : zero_p;
      thr_in.rise_limit   = rise_p[THR_W-1] ? rise_p + PCT_BIAS : rise_p;
      thr_in.drop_limit   = drop_p[THR_W-1] ? drop_p + PCT_BIAS : drop_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else begin
         thr_ff <= thr_in;
      end
   end

   assign cfg = cfg_ff;
   assign thr = thr_ff;

endmodule

// File: rtl/tcm_track.sv
module tcm_track import tcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tcm_cfg_type cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  tcm_req_type req_item,
   output logic        mid_valid,
   input  logic        mid_ready,
   output tcm_mid_type mid_item
);

   logic        stg_valid_ff;
   tcm_req_type stg_item_ff;
   logic        mid_valid_ff;
   tcm_mid_type mid_item_ff;
   tcm_mid_type mid_item_in;

   logic signed [TORQUE_W-1:0] cur_torque_ff, cur_torque_in;
   logic signed [TORQUE_W-1:0] stable_ff, stable_in;
   logic [TICK_W-1:0]          since_frame_ff, since_frame_in;
   logic [TICK_W-1:0]          since_filter_ff, since_filter_in;
   logic                       reported_ff, reported_in;
   logic [COUNT_W-1:0]         frames_ff, frames_in;

   logic                       mid_take;
   logic                       stg_adv;
   logic [TICK_W-1:0]          filter_inc;
   logic                       filter_due;
   logic signed [SUM_W-1:0]    sum;
   logic [MAG_W-1:0]           mag;
   logic [2*MAG_W-1:0]         quot_prod;
   logic [TORQUE_W-1:0]        quot;
   logic signed [TORQUE_W-1:0] filtered;
   logic                       timeout;

   assign mid_take  = !mid_valid_ff || mid_ready;
   assign stg_adv   = stg_valid_ff && mid_take;
   assign req_ready = !stg_valid_ff || mid_take;

   always_comb begin
      // frame capture or watchdog count
      if (stg_item_ff.frame_valid) begin
         cur_torque_in  = stg_item_ff.torque_sample;
         frames_in      = frames_ff + COUNT_W'(1);
         since_frame_in = '0;
      end else begin
         cur_torque_in  = cur_torque_ff;
         frames_in      = frames_ff;
         since_frame_in = (since_frame_ff == TICK_MAX) ? since_frame_ff
                                                        : since_frame_ff + TICK_W'(1);
      end

      // 8:2 low-pass, rounded to nearest with halves away from zero
      filter_inc = (since_filter_ff == TICK_MAX) ? since_filter_ff
                                                  : since_filter_ff + TICK_W'(1);
      filter_due = filter_inc >= cfg.filter_interval;
      sum        = (SUM_W'(stable_ff) <<< 3) + (SUM_W'(cur_torque_in) <<< 1);
      mag        = sum[SUM_W-1] ? MAG_W'(-sum) + ROUND_HALF : MAG_W'(sum) + ROUND_HALF;
      quot_prod  = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, DIV10_MAGIC};
      quot       = quot_prod[DIV10_SHIFT +: TORQUE_W];
      filtered   = sum[SUM_W-1] ? $signed(-quot) : $signed(quot);

      since_filter_in = filter_due ? '0 : filter_inc;
      if (stg_item_ff.rebase) begin
         stable_in = cur_torque_in;
      end else if (filter_due) begin
         stable_in = filtered;
      end else begin
         stable_in = stable_ff;
      end

      // watchdog, warned once per outage
      timeout = since_frame_in >= cfg.timeout_ticks;
      if (timeout) begin
         reported_in = 1'b1;
      end else if (stg_item_ff.frame_valid) begin
         reported_in = 1'b0;
      end else begin
         reported_in = reported_ff;
      end

      mid_item_in.timeout        = timeout;
      mid_item_in.warn           = timeout && (stg_item_ff.frame_valid || !reported_ff);
      mid_item_in.current_torque = cur_torque_in;
      mid_item_in.stable_torque  = stable_in;
      mid_item_in.direction      = stg_item_ff.direction;
      mid_item_in.cable_ok       = stg_item_ff.cable_pos >= cfg.ignore_zone;
      mid_item_in.zero_search    = stg_item_ff.zero_search;
      mid_item_in.frame_count    = frames_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff    <= 1'b0;
         mid_valid_ff    <= 1'b0;
         cur_torque_ff   <= '0;
         stable_ff       <= '0;
         since_frame_ff  <= '0;
         since_filter_ff <= '0;
         reported_ff     <= 1'b0;
         frames_ff       <= '0;
      end else begin
         if (req_ready) begin
            stg_valid_ff <= req_valid;
         end
         if (mid_take) begin
            mid_valid_ff <= stg_valid_ff;
         end
         if (stg_adv) begin
            cur_torque_ff   <= cur_torque_in;
            stable_ff       <= stable_in;
            since_frame_ff  <= since_frame_in;
            since_filter_ff <= since_filter_in;
            reported_ff     <= reported_in;
            frames_ff       <= frames_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_item_ff <= req_item;
      end
      if (stg_adv) begin
         mid_item_ff <= mid_item_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign mid_item  = mid_item_ff;

endmodule

// File: rtl/tcm_judge.sv
module tcm_judge import tcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tcm_cfg_type cfg,
   input  tcm_thr_type thr,
   input  logic        mid_valid,
   output logic        mid_ready,
   input  tcm_mid_type mid_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tcm_rsp_type rsp_item
);

   logic        rsp_valid_ff;
   tcm_rsp_type rsp_item_ff;
   tcm_rsp_type rsp_item_in;

   logic signed [TORQUE_W:0] diff;
   logic signed [THR_W-1:0]  cur100;
   logic signed [THR_W-1:0]  diff100;
   logic signed [THR_W-1:0]  ndiff100;
   logic                     zero_hit;
   logic                     rise_hit;
   logic                     drop_hit;
   logic                     floor_hit;
   cause_type                cause;
   status_type               status;

   function automatic logic signed [THR_W-1:0] mul100(input logic signed [THR_W-1:0] x);
      return (x <<< 6) + (x <<< 5) + (x <<< 2);
   endfunction

   always_comb begin
      diff      = (TORQUE_W+1)'(mid_item.current_torque) - (TORQUE_W+1)'(mid_item.stable_torque);
      cur100    = mul100(THR_W'(mid_item.current_torque));
      diff100   = mul100(THR_W'(diff));
      ndiff100  = -diff100;
      zero_hit  = cur100 > thr.zpoint_limit;
      rise_hit  = diff100 > thr.rise_limit;
      drop_hit  = ndiff100 > thr.drop_limit;
      floor_hit = mid_item.current_torque <= cfg.floor_torque;

      cause = CAUSE_NONE;
      if (!mid_item.timeout && mid_item.cable_ok) begin
         if (mid_item.direction == DIR_UP) begin
            // above the zero limit: flagged unless homing, rise check skipped either way
            if (zero_hit) begin
               cause = mid_item.zero_search ? CAUSE_NONE : CAUSE_ZPOINT;
            end else if (rise_hit) begin
               cause = CAUSE_RISE;
            end
         end else if (mid_item.direction == DIR_DOWN) begin
            if (floor_hit) begin
               cause = CAUSE_FLOOR;
            end else if (drop_hit) begin
               cause = CAUSE_DROP;
            end
         end
      end

      if (mid_item.timeout) begin
         status = STATUS_TIMEOUT;
      end else if (cause != CAUSE_NONE) begin
         status = STATUS_COLLISION;
      end else begin
         status = STATUS_OK;
      end

      rsp_item_in.status          = status;
      rsp_item_in.cause           = cause;
      rsp_item_in.timeout_warning = mid_item.warn;
      rsp_item_in.stable_torque   = mid_item.stable_torque;
      rsp_item_in.frame_count     = mid_item.frame_count;
   end

   assign mid_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mid_ready) begin
         rsp_valid_ff <= mid_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mid_valid && mid_ready) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: rtl/torque_collision_monitor.sv
// an accepted item passes the input register, the state update stage and the result register
// throughput: one item per cycle while the result is not stalled; the state update loop adds no bubble
// a stalled result register holds back the two stages in front of it
// reset (synchronous, active high) empties the pipeline, clears the tracking state
// and loads the register defaults; no clearing pass is needed
module torque_collision_monitor import tcm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcm_req_type           req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tcm_rsp_type           rsp_item,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tcm_cfg_type cfg;
   tcm_thr_type thr;
   logic        mid_valid;
   logic        mid_ready;
   tcm_mid_type mid_item;

   // register file plus the scaled collision limits, which are registered anew
   // from the register file settings every cycle
   tcm_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg),
      .thr          (thr)
   );

   // input register, then frame capture, watchdog, baseline filter and rebase;
   // tracking state is written as the item leaves the input register
   tcm_track u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_item  (mid_item)
   );

   // timeout / collision decision into the result register
   tcm_judge u_judge (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .thr       (thr),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_item  (mid_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// File: rtl/tcm_checker.sv
module tcm_checker import tcm_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input tcm_rsp_type rsp_item
);

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a timeout item carries no collision cause
   a_timeout_no_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STATUS_TIMEOUT) |-> rsp_item.cause == CAUSE_NONE)
      else $error("cause set on timeout item");

   // the warning only shows on a timed-out item
   a_warn_on_timeout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.timeout_warning) |-> rsp_item.status == STATUS_TIMEOUT)
      else $error("timeout warning without timeout status");

   // collision status and a cause go together
   a_collision_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.status == STATUS_COLLISION) == (rsp_item.cause != CAUSE_NONE)))
      else $error("collision status and cause disagree");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed");

endmodule

bind torque_collision_monitor tcm_checker u_checker (.*);
